// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
package bba_pkg;

    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 13;
    localparam int TDATA_W  = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
    // blocks 0 and 1 stay reserved
    localparam logic [WORD_W-1:0]  RESERVED_WORD = 64'h3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                clear_step;
        logic                start_alloc;
        logic                scan_step;
        logic                free_read;
        logic                alloc_write;
        logic                free_write;
        logic                res_load;
        logic                res_grant;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic past_limit;
        logic word_full;
        logic hit;
        logic free_bad;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/bba_ctrl.sv -----
`include "assert_macros.svh"

module bba_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    input  bba_pkg::dp_status_t  stat,
    output bba_pkg::dp_cmd_t     cmd
);

    bba_pkg::state_t state_reg;
    bba_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bba_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::ST_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_op == bba_pkg::OP_ALLOC) begin
                        state_next = bba_pkg::ST_SCAN;
                    end else if (stat.free_bad) begin
                        state_next = bba_pkg::ST_DONE;
                    end else begin
                        state_next = bba_pkg::ST_FREE_WR;
                    end
                end
            end
            bba_pkg::ST_SCAN: begin
                if (stat.past_limit || !stat.word_full) begin
                    state_next = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_FREE_WR: begin
                state_next = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            bba_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            bba_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_op == bba_pkg::OP_ALLOC) begin
                        cmd.start_alloc = 1'b1;
                    end else if (stat.free_bad) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = bba_pkg::STAT_BAD;
                    end else begin
                        cmd.free_read = 1'b1;
                    end
                end
            end
            bba_pkg::ST_SCAN: begin
                if (stat.past_limit) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bba_pkg::STAT_FULL;
                end else if (stat.word_full) begin
                    cmd.scan_step = 1'b1;
                end else if (stat.hit) begin
                    cmd.alloc_write = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res_grant   = 1'b1;
                    cmd.res_status  = bba_pkg::STAT_OK;
                end else begin
                    // lowest clear bit lies beyond the usable count
                    cmd.res_load   = 1'b1;
                    cmd.res_status = bba_pkg::STAT_FULL;
                end
            end
            bba_pkg::ST_FREE_WR: begin
                cmd.free_write = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = bba_pkg::STAT_OK;
            end
            bba_pkg::ST_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `BBA_ASSERT_IMP(a_one_writer, aclk, aresetn, 1'b1,
        $onehot0({cmd.clear_step, cmd.alloc_write, cmd.free_write}),
        "more than one bitmap write source active")

    `BBA_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn,
        in_valid && in_ready, state_reg != bba_pkg::ST_IDLE,
        "accepted item did not start work")

endmodule

// ----- rtl/core/bba_dpath.sv -----
`include "assert_macros.svh"

module bba_dpath #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bba_pkg::TOTAL_W-1:0]     cfg_wr_data,
    input  logic [bba_pkg::INDEX_W-1:0]     in_index,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [bba_pkg::STATUS_W-1:0]    out_status,
    output logic [bba_pkg::INDEX_W-1:0]     out_granted,
    input  bba_pkg::dp_cmd_t                cmd,
    output bba_pkg::dp_status_t             stat
);

    localparam int WORD_COUNT = (MAX_BLOCKS + 63) / 64;
    localparam int AW         = $clog2(WORD_COUNT);
    localparam int PTR_W      = $clog2(WORD_COUNT + 1);
    localparam int CNT_W      = (PTR_W + bba_pkg::BIT_W > bba_pkg::TOTAL_W) ?
                                (PTR_W + bba_pkg::BIT_W) : bba_pkg::TOTAL_W;
    localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_BLOCKS);
    localparam logic [PTR_W-1:0] LAST_WORD  = PTR_W'(WORD_COUNT - 1);
    localparam logic [PTR_W-1:0] WORDS_PTR  = PTR_W'(WORD_COUNT);

    logic [bba_pkg::WORD_W-1:0]   bitmap_mem [WORD_COUNT];
    logic [bba_pkg::WORD_W-1:0]   rd_data_reg;
    logic [PTR_W-1:0]             word_reg;
    logic [PTR_W-1:0]             word_next;
    logic [bba_pkg::BIT_W-1:0]    bit_reg;
    logic [bba_pkg::TOTAL_W-1:0]  total_reg;
    logic [bba_pkg::STATUS_W-1:0] res_status_reg;
    logic [bba_pkg::INDEX_W-1:0]  res_granted_reg;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [bba_pkg::STATUS_W-1:0] m_status_reg;
    logic [bba_pkg::INDEX_W-1:0]  m_granted_reg;

    logic [CNT_W-1:0]             total_ext;
    logic [CNT_W-1:0]             limit;
    logic [CNT_W-1:0]             base;
    logic [CNT_W-1:0]             cand;
    logic [CNT_W-1:0]             idx_ext;
    logic [PTR_W-1:0]             in_word;
    logic [bba_pkg::WORD_W-1:0]   clear_onehot;
    logic [bba_pkg::BIT_W-1:0]    clear_pos;
    logic [PTR_W-1:0]             rd_ptr;
    logic                         rd_en;
    logic                         wr_en;
    logic [bba_pkg::WORD_W-1:0]   wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= bba_pkg::TOTAL_RESET;
        end else if (cfg_wr_en) begin
            total_reg <= cfg_wr_data;
        end
    end

    assign total_ext = CNT_W'(total_reg);
    assign limit     = (total_ext < MAX_CNT) ? total_ext : MAX_CNT;

    // scan of the word held in rd_data_reg
    assign base         = CNT_W'({word_reg, {bba_pkg::BIT_W{1'b0}}});
    assign clear_onehot = ~rd_data_reg & (rd_data_reg + 64'd1);

    always_comb begin
        clear_pos = '0;
        for (int i = 0; i < bba_pkg::WORD_W; i++) begin
            if (clear_onehot[i]) begin
                clear_pos = clear_pos | bba_pkg::BIT_W'(i);
            end
        end
    end

    assign cand = base | CNT_W'(clear_pos);

    // free request checks on the incoming item
    assign idx_ext = CNT_W'(in_index);
    assign in_word = PTR_W'(idx_ext >> bba_pkg::BIT_W);

    assign stat.clear_last = (word_reg == LAST_WORD);
    assign stat.past_limit = (base >= limit);
    assign stat.word_full  = &rd_data_reg;
    assign stat.hit        = (cand < limit);
    assign stat.free_bad   = (idx_ext < CNT_W'(2)) || (idx_ext >= limit);
    assign stat.out_free   = !m_valid_reg || out_ready;

    always_comb begin
        word_next = word_reg;
        if (cmd.clear_step || cmd.scan_step) begin
            word_next = word_reg + PTR_W'(1);
        end else if (cmd.start_alloc) begin
            word_next = '0;
        end else if (cmd.free_read) begin
            word_next = in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.free_read) begin
            bit_reg <= in_index[bba_pkg::BIT_W-1:0];
        end
    end

    // read port: word 0 at the start of an allocate, the next word of a scan, or the word of a free
    always_comb begin
        rd_ptr = '0;
        if (cmd.scan_step) begin
            rd_ptr = word_reg + PTR_W'(1);
        end else if (cmd.free_read) begin
            rd_ptr = in_word;
        end
    end

    assign rd_en = (cmd.start_alloc || cmd.scan_step || cmd.free_read) &&
                   (rd_ptr < WORDS_PTR);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= bitmap_mem[rd_ptr[AW-1:0]];
        end
    end

    always_comb begin
        wr_en   = cmd.clear_step || cmd.alloc_write || cmd.free_write;
        wr_data = '0;
        if (cmd.clear_step) begin
            wr_data = (word_reg == '0) ? bba_pkg::RESERVED_WORD : '0;
        end else if (cmd.alloc_write) begin
            wr_data = rd_data_reg | clear_onehot;
        end else if (cmd.free_write) begin
            wr_data = rd_data_reg & ~(64'd1 << bit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bitmap_mem[word_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg  <= cmd.res_status;
            res_granted_reg <= cmd.res_grant ? cand[bba_pkg::INDEX_W-1:0] : '0;
        end
    end

    // output register: holds the result until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_granted_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_status  = m_status_reg;
    assign out_granted = m_granted_reg;

    `BBA_ASSERT_IMP(a_grant_in_range, aclk, aresetn, cmd.alloc_write,
        (clear_onehot != '0) && (cand < limit) && (base < limit),
        "allocation outside the usable blocks")

    `BBA_ASSERT_IMP(a_zero_grant_on_error, aclk, aresetn,
        m_valid_reg && (m_status_reg != bba_pkg::STAT_OK), m_granted_reg == '0,
        "nonzero granted block on a failed request")

endmodule

// ----- rtl/core/block_bitmap_allocator.sv -----
// Allocate: scans from word 0, skipping full words one word per cycle (up to 64 words at 4096
// blocks); free: reads the word of its index and writes it back, a bad index leaves the bitmap alone.
// Throughput: one item at a time; the next item is accepted once the result has entered the
// output register, which holds it until m_tready.
// Reset: synchronous, active low; total_blocks returns to 4096, then a clearing pass over
// (MAX_BLOCKS+63)/64 words (64 by default) sets the bitmap, s_tready held low.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bba_pkg::TOTAL_W-1:0]    cfg_wr_data,   // total_blocks
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bba_pkg::TDATA_W-1:0]    s_tdata,       // [11:0] block_index
    input  logic [0:0]                     s_tuser,       // [0] opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bba_pkg::TDATA_W-1:0]    m_tdata,       // [11:0] granted_block
    output logic [bba_pkg::STATUS_W-1:0]   m_tuser        // [1:0] status
);

    bba_pkg::dp_cmd_t               cmd;
    bba_pkg::dp_status_t            stat;
    logic [bba_pkg::INDEX_W-1:0]    granted;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_index    (s_tdata[bba_pkg::INDEX_W-1:0]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_granted (granted),
        .cmd         (cmd),
        .stat        (stat)
    );

    assign m_tdata = {{(bba_pkg::TDATA_W - bba_pkg::INDEX_W){1'b0}}, granted};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int USABLE_MAX  = 4096;
    localparam int WORDS       = USABLE_MAX / bba_pkg::WORD_W;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_GOAL = 820;

    typedef struct packed {
        logic [bba_pkg::STATUS_W-1:0] status;
        logic [bba_pkg::TDATA_W-1:0]  block;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [bba_pkg::WORD_W-1:0]  used_words [WORDS];
        logic [bba_pkg::TOTAL_W-1:0] total_blocks;
        alloc_result_t               expected_q [$];
        int                          granted_q [$];
        int                          errors;

        function new();
            foreach (used_words[w]) used_words[w] = '0;
            used_words[0] = bba_pkg::RESERVED_WORD;
            total_blocks  = bba_pkg::TOTAL_RESET;
            errors        = 0;
        endfunction

        function void set_total(logic [bba_pkg::TOTAL_W-1:0] value);
            total_blocks = value;
        endfunction

        function int usable();
            return (total_blocks < USABLE_MAX) ? int'(total_blocks) : USABLE_MAX;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted item and update the bitmap.
        function void note_item(logic op, logic [bba_pkg::INDEX_W-1:0] idx);
            int            lim;
            int            b;
            int            cand;
            alloc_result_t res;
            lim        = usable();
            res.status = bba_pkg::STAT_FULL;
            res.block  = '0;
            if (op == bba_pkg::OP_ALLOC) begin
                for (int w = 0; w < WORDS; w++) begin
                    if (w * bba_pkg::WORD_W >= lim) break;
                    if (&used_words[w]) continue;
                    b = 0;
                    while (b < bba_pkg::WORD_W && used_words[w][b]) b++;
                    cand = w * bba_pkg::WORD_W + b;
                    if (cand < lim) begin
                        used_words[w][b] = 1'b1;
                        res.status = bba_pkg::STAT_OK;
                        res.block  = bba_pkg::TDATA_W'(cand);
                        granted_q.push_back(cand);
                    end
                    break;
                end
            end else if (idx < 2 || int'(idx) >= lim) begin
                res.status = bba_pkg::STAT_BAD;
            end else begin
                used_words[idx[bba_pkg::INDEX_W-1:bba_pkg::BIT_W]][idx[bba_pkg::BIT_W-1:0]] = 1'b0;
                res.status = bba_pkg::STAT_OK;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [bba_pkg::STATUS_W-1:0] status,
                                   logic [bba_pkg::TDATA_W-1:0] block);
            alloc_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d block %0d", status, block);
                return;
            end
            want = expected_q.pop_front();
            if (status !== want.status || block !== want.block) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d block %0d, got status %0d block %0d",
                             want.status, want.block, status, block);
            end
        endfunction
    endclass

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [bba_pkg::TOTAL_W-1:0]   cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [bba_pkg::TDATA_W-1:0]   s_tdata     = '0;
    logic [0:0]                    s_tuser     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [bba_pkg::TDATA_W-1:0]   m_tdata;
    logic [bba_pkg::STATUS_W-1:0]  m_tuser;

    alloc_scoreboard sb;
    int              cycles    = 0;
    int              sent      = 0;
    int              send_calm = 0;
    int              recv_calm = 0;

    block_bitmap_allocator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Wait per item: mostly random, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(10, 30);
        return $urandom_range(0, 16);
    endfunction

    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = draw_wait(recv_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_tvalid)) @(posedge aclk);
        end
    end

    task automatic send_item(input logic op, input logic [bba_pkg::INDEX_W-1:0] idx);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(bba_pkg::TDATA_W-bba_pkg::INDEX_W){1'b0}}, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(op, idx);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_total(input logic [bba_pkg::TOTAL_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_total(value);
    endtask

    task automatic alloc_item();
        send_item(bba_pkg::OP_ALLOC, bba_pkg::INDEX_W'($urandom_range(0, 4095)));
    endtask

    // Free mostly blocks handed out earlier, otherwise any index up to just past the limit, or any index.
    task automatic free_item();
        int r;
        int k;
        int hi;
        int idx;
        r  = $urandom_range(0, 99);
        hi = sb.usable() + 3;
        if (hi > 4095) hi = 4095;
        if (r < 60 && sb.granted_q.size() > 0) begin
            k   = $urandom_range(0, sb.granted_q.size() - 1);
            idx = sb.granted_q[k];
            sb.granted_q.delete(k);
        end else if (r < 85) begin
            idx = $urandom_range(0, hi);
        end else begin
            idx = $urandom_range(0, 4095);
        end
        send_item(bba_pkg::OP_FREE, bba_pkg::INDEX_W'(idx));
    endtask

    task automatic run_phase(input int count, input int alloc_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < alloc_pct)
                alloc_item();
            else
                free_item();
        end
    endtask

    initial begin
        int r;
        int total;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // hold off through the clearing pass
        repeat (80) @(posedge aclk);

        write_total(bba_pkg::TOTAL_RESET);
        send_item(bba_pkg::OP_ALLOC, 12'd0);
        send_item(bba_pkg::OP_ALLOC, 12'hFFF);
        send_item(bba_pkg::OP_FREE, 12'd0);
        send_item(bba_pkg::OP_FREE, 12'd1);
        send_item(bba_pkg::OP_FREE, 12'hFFF);
        send_item(bba_pkg::OP_FREE, 12'd2);
        send_item(bba_pkg::OP_ALLOC, 12'hAAA);
        send_item(bba_pkg::OP_FREE, 12'd3);
        send_item(bba_pkg::OP_ALLOC, 12'h555);
        send_item(bba_pkg::OP_FREE, 12'd4094);
        send_item(bba_pkg::OP_ALLOC, 12'd0);

        write_total(13'd2);
        send_item(bba_pkg::OP_ALLOC, 12'd0);
        send_item(bba_pkg::OP_FREE, 12'd2);
        send_item(bba_pkg::OP_FREE, 12'd1);
        send_item(bba_pkg::OP_FREE, 12'hFFF);

        write_total(13'd5);
        send_item(bba_pkg::OP_ALLOC, 12'd0);
        send_item(bba_pkg::OP_ALLOC, 12'd0);
        send_item(bba_pkg::OP_FREE, 12'd4);
        send_item(bba_pkg::OP_ALLOC, 12'd0);

        // lowered below blocks still in use
        write_total(13'd3);
        send_item(bba_pkg::OP_FREE, 12'd3);
        send_item(bba_pkg::OP_FREE, 12'd4);
        send_item(bba_pkg::OP_ALLOC, 12'd0);

        sb.granted_q.delete();
        while (sent < RANDOM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                total = 2;
            else if (r < 22)
                total = 4096;
            else if (r < 32)
                total = $urandom_range(301, 4095);
            else
                total = $urandom_range(3, 300);
            write_total(bba_pkg::TOTAL_W'(total));
            run_phase($urandom_range(30, 90), $urandom_range(0, 1) ? 80 : 35);
        end

        drain();
        repeat (80) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
